// ===== src/sacl_pkg.sv =====
package sacl_pkg;

   localparam int ADDR_W    = 32;
   localparam int TAG_W     = 32;
   localparam int OFFSET_W  = 24;
   localparam int SET_OUT_W = 8;
   localparam int WAY_OUT_W = 3;
   localparam int COUNT_W   = 32;

   // one tag slot in a row: valid bit on top of the tag
   localparam int SLOT_W = TAG_W + 1;

   // widest way number the status struct carries (up to 64 ways)
   localparam int WAY_IDX_MAX_W = 6;

   localparam int OB_W = 5;
   localparam int SB_W = 4;
   localparam int WU_W = 4;
   localparam logic [OB_W-1:0] OFFSET_LIMIT = 5'd24;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLK_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [OB_W-1:0] BLK_BITS_RST    = 5'd4;
   localparam logic [SB_W-1:0] SET_BITS_RST    = 4'd0;
   localparam logic [WU_W-1:0] WAYS_IN_USE_RST = 4'd8;

   typedef struct packed {
      logic start;
      logic step;
   } scan_ctrl_type;

   typedef struct packed {
      logic                     done;
      logic                     hit;
      logic [WAY_IDX_MAX_W-1:0] way;
   } scan_stat_type;

endpackage

// ===== src/sacl_req_if.sv =====
interface sacl_req_if;
   import sacl_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

// ===== src/sacl_rsp_if.sv =====
interface sacl_rsp_if;
   import sacl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [SET_OUT_W-1:0] set_index;
   logic [WAY_OUT_W-1:0] way;
   logic [TAG_W-1:0]     tag_value;
   logic [OFFSET_W-1:0]  byte_offset;
   logic [COUNT_W-1:0]   hit_total;
   logic [COUNT_W-1:0]   miss_total;

   modport source (output valid, output hit, output set_index, output way, output tag_value,
                   output byte_offset, output hit_total, output miss_total, input ready);
   modport sink   (input valid, input hit, input set_index, input way, input tag_value,
                   input byte_offset, input hit_total, input miss_total, output ready);
endinterface

// ===== src/sacl_ram.sv =====
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/sacl_addr_split.sv =====
module sacl_addr_split #(
   parameter int SET_LIM = 8,
   parameter int SET_AW  = 8
) (
   input  logic [sacl_pkg::ADDR_W-1:0]   address,
   input  logic [sacl_pkg::OB_W-1:0]     blk_bits,
   input  logic [sacl_pkg::SB_W-1:0]     set_bits,
   output logic [sacl_pkg::OFFSET_W-1:0] byte_offset,
   output logic [SET_AW-1:0]             set_index,
   output logic [sacl_pkg::TAG_W-1:0]    tag_value
);
   import sacl_pkg::*;

   logic [OB_W-1:0]   ob;
   logic [SB_W-1:0]   sb;
   logic [OB_W:0]     tag_shift;
   logic [ADDR_W-1:0] above_offset;
   logic [ADDR_W-1:0] offset_mask;
   logic [ADDR_W-1:0] set_mask;

   // clamp the geometry to what the store can hold
   assign ob = (blk_bits > OFFSET_LIMIT) ? OFFSET_LIMIT : blk_bits;
   assign sb = (32'(set_bits) > SET_LIM) ? SB_W'(SET_LIM) : set_bits;
   assign tag_shift = (OB_W + 1)'(ob) + (OB_W + 1)'(sb);

   assign offset_mask  = ~({ADDR_W{1'b1}} << ob);
   assign set_mask     = ~({ADDR_W{1'b1}} << sb);
   assign above_offset = address >> ob;

   assign byte_offset = OFFSET_W'(address & offset_mask);
   assign set_index   = SET_AW'(above_offset & set_mask);
   // a shift of 32 or more leaves no tag bits
   assign tag_value   = address >> tag_shift;
endmodule

// ===== src/sacl_way_scan.sv =====
module sacl_way_scan #(
   parameter int WAYS  = 8,
   parameter int WAY_W = 3,
   parameter int NW_W  = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sacl_pkg::scan_ctrl_type              ctrl,
   input  logic [WAYS*sacl_pkg::SLOT_W-1:0]     row,
   input  logic [sacl_pkg::TAG_W-1:0]           tag,
   input  logic [NW_W-1:0]                      nw,
   output sacl_pkg::scan_stat_type              stat
);
   import sacl_pkg::*;

   logic [WAY_W-1:0]  way_ff;
   logic [WAY_W-1:0]  way_in;
   logic [SLOT_W-1:0] slot;
   logic              match;
   logic              last;

   // one comparator, walked across the ways
   assign slot  = row[way_ff*SLOT_W +: SLOT_W];
   assign match = slot[SLOT_W-1] && (slot[TAG_W-1:0] == tag);
   assign last  = (32'(way_ff) + 32'd1) >= 32'(nw);

   assign stat.done = ctrl.step && (match || last);
   assign stat.hit  = match;
   assign stat.way  = WAY_IDX_MAX_W'(way_ff);

   always_comb begin
      way_in = way_ff;
      if (ctrl.start) begin
         way_in = '0;
      end else if (ctrl.step && !stat.done) begin
         way_in = way_ff + WAY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         way_ff <= '0;
      end else begin
         way_ff <= way_in;
      end
   end
endmodule

// ===== src/set_assoc_cache_tag_lookup_top.sv =====
// Set-associative cache tag lookup with round-robin replacement.
//
// req carries one byte address per request (valid/ready). rsp returns one
// result per request: hit flag, set, way, tag, byte offset and the running
// hit and miss totals after this access. csr_write_en/csr_index/csr_wdata
// write the block offset bits (0), set_bits (1) and ways_in_use (2); write
// them only while no request is in flight.
//
// Each set is one row of the tag RAM (valid bit and tag per way). The row is
// read when a request is taken, then a single tag comparator steps through
// the ways one per cycle until a hit or the last way in use, and the finish
// state, once the response register is free, writes the victim on a miss and
// loads the response register. nw is the ways in use clamped to 1..WAYS.
//
// After reset the block sweeps the tag RAM clear, one row a cycle, over all
// 2^floor(log2 MAX_SETS) rows (256 by default), with req.ready low.
// A stalled rsp holds its result; req is taken again once it is loaded.
module set_assoc_cache_tag_lookup_top #(
   parameter int MAX_SETS = 256,
   parameter int WAYS     = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   sacl_req_if.sink                          req,
   sacl_rsp_if.source                        rsp,
   input  logic                              csr_write_en,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sacl_pkg::*;

   // set bits the store can hold: floor of log2 MAX_SETS
   localparam int SET_LIM   = $clog2(MAX_SETS + 1) - 1;
   localparam int SET_AW    = (SET_LIM > 0) ? SET_LIM : 1;
   localparam int RAM_DEPTH = 1 << SET_LIM;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NW_W      = $clog2(WAYS + 1);
   localparam int ROW_W     = WAYS * SLOT_W;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [OB_W-1:0] blk_bits_ff;
   logic [SB_W-1:0] set_bits_ff;
   logic [WU_W-1:0] ways_in_use_ff;
   logic [NW_W-1:0] nw;

   // request fields held for the walk
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [SET_AW-1:0]   set_ff, set_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;

   // walk result
   logic             hit_ff;
   logic [WAY_W-1:0] hit_way_ff;

   logic [WAY_W-1:0]   victim_ff, victim_in;
   logic [COUNT_W-1:0] hits_ff, misses_ff;
   logic [SET_AW-1:0]  clr_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [SET_OUT_W-1:0] rsp_set_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;
   logic [TAG_W-1:0]     rsp_tag_ff;
   logic [OFFSET_W-1:0]  rsp_offset_ff;

   logic accept;
   logic out_free;
   logic finish;
   logic clr_last;

   logic              ram_we;
   logic [SET_AW-1:0] ram_waddr;
   logic [ROW_W-1:0]  ram_wdata;
   logic [ROW_W-1:0]  row;
   logic [ROW_W-1:0]  row_fill;

   scan_ctrl_type scan_ctrl;
   scan_stat_type scan_stat;

   // clamp ways in use to 1..WAYS
   always_comb begin
      if (ways_in_use_ff == '0) begin
         nw = NW_W'(1);
      end else if (32'(ways_in_use_ff) > WAYS) begin
         nw = NW_W'(WAYS);
      end else begin
         nw = NW_W'(ways_in_use_ff);
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign finish    = (state_ff == ST_FINISH) && out_free;
   assign clr_last  = (clr_ff == SET_AW'(RAM_DEPTH - 1));

   sacl_addr_split #(
      .SET_LIM (SET_LIM),
      .SET_AW  (SET_AW)
   ) u_split (
      .address     (req.address),
      .blk_bits    (blk_bits_ff),
      .set_bits    (set_bits_ff),
      .byte_offset (offset_in),
      .set_index   (set_in),
      .tag_value   (tag_in)
   );

   // advance the round-robin pointer, wrapping at the ways in use
   assign victim_in = ((32'(victim_ff) + 32'd1) >= 32'(nw)) ? '0 : victim_ff + WAY_W'(1);

   always_comb begin
      row_fill = row;
      row_fill[victim_in*SLOT_W +: SLOT_W] = {1'b1, tag_ff};
   end

   // the clearing sweep and the victim fill share the one write port
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = finish && !hit_ff;
         ram_waddr = set_ff;
         ram_wdata = row_fill;
      end
   end

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (RAM_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (set_in),
      .rd_data (row)
   );

   assign scan_ctrl.start = accept;
   assign scan_ctrl.step  = (state_ff == ST_SCAN);

   sacl_way_scan #(
      .WAYS  (WAYS),
      .WAY_W (WAY_W),
      .NW_W  (NW_W)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .ctrl  (scan_ctrl),
      .row   (row),
      .tag   (tag_ff),
      .nw    (nw),
      .stat  (scan_stat)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         blk_bits_ff    <= BLK_BITS_RST;
         set_bits_ff    <= SET_BITS_RST;
         ways_in_use_ff <= WAYS_IN_USE_RST;
         victim_ff      <= '0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + SET_AW'(1);
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_BLK_BITS:    blk_bits_ff    <= csr_wdata[OB_W-1:0];
               CSR_SET_BITS:    set_bits_ff    <= csr_wdata[SB_W-1:0];
               CSR_WAYS_IN_USE: ways_in_use_ff <= csr_wdata[WU_W-1:0];
               default: begin
                  // unknown index: drop the write
               end
            endcase
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            if (hit_ff) begin
               hits_ff <= hits_ff + COUNT_W'(1);
            end else begin
               misses_ff <= misses_ff + COUNT_W'(1);
               victim_ff <= victim_in;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         offset_ff <= offset_in;
         set_ff    <= set_in;
         tag_ff    <= tag_in;
      end
      if (scan_stat.done) begin
         hit_ff     <= scan_stat.hit;
         hit_way_ff <= scan_stat.way[WAY_W-1:0];
      end
      if (finish) begin
         rsp_hit_ff    <= hit_ff;
         rsp_set_ff    <= SET_OUT_W'(set_ff);
         rsp_way_ff    <= hit_ff ? WAY_OUT_W'(hit_way_ff) : WAY_OUT_W'(victim_in);
         rsp_tag_ff    <= tag_ff;
         rsp_offset_ff <= offset_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = rsp_hit_ff;
   assign rsp.set_index   = rsp_set_ff;
   assign rsp.way         = rsp_way_ff;
   assign rsp.tag_value   = rsp_tag_ff;
   assign rsp.byte_offset = rsp_offset_ff;
   assign rsp.hit_total   = hits_ff;
   assign rsp.miss_total  = misses_ff;

`ifndef SYNTHESIS
   // a taken request always starts the way walk
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("request taken without starting the way walk");

   // a hit never names a way outside the ways in use
   a_hit_way_in_use: assert property (@(posedge clock) disable iff (reset)
      (scan_stat.done && scan_stat.hit) |-> (32'(scan_stat.way) < 32'(nw)))
      else $error("hit reported in a way not in use");

   // the row under comparison is never overwritten during the walk
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_we)
      else $error("tag RAM written while a row is being compared");

   // each finished request adds exactly one to the hit or the miss total
   a_one_count: assert property (@(posedge clock) disable iff (reset)
      finish |=> ((hits_ff + misses_ff) == ($past(hits_ff) + $past(misses_ff) + 32'd1)))
      else $error("totals did not advance by one for a finished request");
`endif
endmodule
